### hdl/fts_pkg.sv
// fts_pkg: shared types, sizes and command codes for the FIFO task scheduler.
// No dependencies.
package fts_pkg;

  localparam int unsigned MAX_TASKS  = 16;
  localparam int unsigned NUM_EVENTS = 8;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_WAIT  = 2'd1;
  localparam logic [1:0] CMD_DISP  = 2'd2;
  localparam logic [1:0] CMD_SCHED = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  task_id;
    logic        task_priority;
    logic [2:0]  event_id;
    logic [31:0] data_word;
    logic        requeue;
  } fts_in_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  out_task;
    logic [31:0] out_data;
    logic        switched;
    logic        last;
  } fts_out_t;

endpackage

### hdl/fts_link_mem.sv
// fts_link_mem: next-link store shared by the ready and wait lists.
// Depends on nothing; one write port, one registered read port.
module fts_link_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/fifo_task_scheduler_with_event_waits.sv
// fifo_task_scheduler_with_event_waits: top level, command sequencer and task state.
// Depends on fts_pkg and fts_link_mem.
//
// Usage: drive in_item and raise start while busy is low; the item is taken at
// that edge and busy rises at once. Results appear on out_item, each for one
// cycle with out_valid high; the final result of a command has last set.
// add_ready shows its report and no other result.
// wait and schedule with a nonempty ready list do one link read, then check one
// entry per cycle until a task is chosen, then show the report; with an empty
// ready list they show the report without a walk.
// dispatch wakes the waiters in order, a link read then a step for each, and shows
// a result for each, then the running report (only that with no waiters).
// The link store read port sets the pace of every walk.
// busy is low in the cycle of the final report, so the next item can be taken then.
// Reset (rst_n low, synchronous) empties the ready list and all wait lists,
// clears the priority bits and data words (the data words in a clearing pass
// with busy held high), and makes task 0 the running task.
// The receiver cannot stall: every result is taken in the cycle it is shown.
module fifo_task_scheduler_with_event_waits
  import fts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  fts_in_t  in_item,
  output logic     out_valid,
  output fts_out_t out_item
);

  localparam int unsigned TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned EW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int unsigned SW = $clog2(MAX_TASKS + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SEL0  = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SCHK  = 4'd4;
  localparam logic [3:0] S_SFIX  = 4'd5;
  localparam logic [3:0] S_DRD   = 4'd6;
  localparam logic [3:0] S_DSTEP = 4'd7;
  localparam logic [3:0] S_REP   = 4'd8;
  localparam logic [3:0] S_HRD   = 4'd9;

  logic [3:0]    state_r, state_nxt;
  fts_in_t       cmd_r;
  logic [TW-1:0] rhead_r, rtail_r, run_r, cur_r, prev_r;
  logic          rne_r, hasprev_r, sw_r;
  logic [SW-1:0] steps_r;
  logic [TW-1:0] whead_r [NUM_EVENTS];
  logic [TW-1:0] wtail_r [NUM_EVENTS];
  logic [NUM_EVENTS-1:0] wne_r;
  logic          prio_r [MAX_TASKS];
  logic [31:0]   word_mem [MAX_TASKS];
  logic [31:0]   word_rd;
  logic [TW-1:0] word_ra;
  logic          word_we;
  logic [TW-1:0] word_wa;
  logic [31:0]   word_wd;
  logic [TW-1:0] clr_r;

  logic          lk_we;
  logic [TW-1:0] lk_wa, lk_wd, lk_ra, lk_rd;

  logic [TW-1:0] tid, ev_run;
  logic [EW-1:0] ev;

  assign tid = TW'(32'(cmd_r.task_id) % MAX_TASKS);
  assign ev  = EW'(32'(cmd_r.event_id) % NUM_EVENTS);
  assign ev_run = run_r;

  fts_link_mem #(.DEPTH(MAX_TASKS), .AW(TW)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd)
  );

  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[word_wa] <= word_wd;
    end
    word_rd <= word_mem[word_ra];
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    lk_we = 1'b0;
    lk_wa = cur_r;
    lk_wd = cur_r;
    lk_ra = cur_r;
    word_we = 1'b0;
    word_wa = cur_r;
    word_wd = cmd_r.data_word;
    word_ra = run_r;
    unique case (state_r)
      S_CLR: begin
        word_we = 1'b1;
        word_wa = clr_r;
        word_wd = '0;
        if (32'(clr_r) == MAX_TASKS - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_SEL0;
      end
      S_SEL0: begin
        unique case (cmd_r.cmd)
          CMD_ADD: begin
            if (rne_r) begin
              lk_we = 1'b1; lk_wa = rtail_r; lk_wd = tid;
            end
            state_nxt = S_REP;
          end
          CMD_WAIT: begin
            word_we = 1'b1; word_wa = run_r;
            if (wne_r[ev]) begin
              lk_we = 1'b1; lk_wa = wtail_r[ev]; lk_wd = run_r;
            end
            state_nxt = rne_r ? S_SRD : S_REP;
          end
          CMD_SCHED: begin
            if (rne_r && cmd_r.requeue) begin
              lk_we = 1'b1; lk_wa = rtail_r; lk_wd = run_r;
            end
            state_nxt = rne_r ? S_SRD : S_REP;
          end
          default: begin
            lk_ra = whead_r[ev];
            state_nxt = wne_r[ev] ? S_DRD : S_REP;
          end
        endcase
      end
      S_SRD: begin
        lk_ra = cur_r;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (prio_r[cur_r] || cur_r == rtail_r || 32'(steps_r) >= MAX_TASKS) begin
          state_nxt = S_SFIX;
          if (hasprev_r && cur_r != rtail_r) begin
            lk_we = 1'b1; lk_wa = prev_r; lk_wd = lk_rd;
          end
        end else begin
          lk_ra = lk_rd;
          state_nxt = S_SCHK;
        end
      end
      S_SFIX: begin
        word_ra = cur_r;
        state_nxt = S_HRD;
      end
      S_HRD: begin
        state_nxt = S_REP;
      end
      S_DRD: begin
        lk_ra = cur_r;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        word_we = 1'b1; word_wa = cur_r;
        if (rne_r) begin
          lk_we = 1'b1; lk_wa = rtail_r; lk_wd = cur_r;
        end
        if (cur_r == wtail_r[ev] || 32'(steps_r) >= MAX_TASKS - 1) begin
          state_nxt = S_HRD;
        end else begin
          state_nxt = S_DRD;
        end
      end
      S_REP: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // S_SCHK: the link read issued with cur_r in S_SRD returns link(cur) in lk_rd.
  // On advance, cur moves to lk_rd and the next read of link(lk_rd) is issued.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      rhead_r <= '0;
      rtail_r <= '0;
      rne_r <= 1'b0;
      run_r <= '0;
      wne_r <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) prio_r[i] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= 1'b0;
      unique case (state_r)
        S_CLR: clr_r <= clr_r + 1'b1;
        S_IDLE: begin
          if (start) cmd_r <= in_item;
          sw_r <= 1'b0;
        end
        S_SEL0: begin
          steps_r <= SW'(1);
          hasprev_r <= 1'b0;
          unique case (cmd_r.cmd)
            CMD_ADD: begin
              prio_r[tid] <= cmd_r.task_priority;
              if (!rne_r) rhead_r <= tid;
              rtail_r <= tid;
              rne_r <= 1'b1;
            end
            CMD_WAIT: begin
              if (!wne_r[ev]) whead_r[ev] <= run_r;
              wtail_r[ev] <= run_r;
              wne_r[ev] <= 1'b1;
              cur_r <= rhead_r;
            end
            CMD_SCHED: begin
              cur_r <= rhead_r;
              if (rne_r && cmd_r.requeue) rtail_r <= run_r;
            end
            default: begin
              cur_r <= whead_r[ev];
              steps_r <= '0;
            end
          endcase
        end
        S_SCHK: begin
          if (prio_r[cur_r] || cur_r == rtail_r || 32'(steps_r) >= MAX_TASKS) begin
            if (!hasprev_r) begin
              if (cur_r == rtail_r) rne_r <= 1'b0;
              else rhead_r <= lk_rd;
            end else if (cur_r == rtail_r) begin
              rtail_r <= prev_r;
            end
            run_r <= cur_r;
            sw_r <= 1'b1;
          end else begin
            prev_r <= cur_r;
            hasprev_r <= 1'b1;
            cur_r <= lk_rd;
            steps_r <= steps_r + 1'b1;
          end
        end
        S_DSTEP: begin
          if (!rne_r) rhead_r <= cur_r;
          rtail_r <= cur_r;
          rne_r <= 1'b1;
          out_valid <= 1'b1;
          out_item.kind <= 1'b1;
          out_item.out_task <= 4'(cur_r);
          out_item.out_data <= cmd_r.data_word;
          out_item.switched <= 1'b0;
          out_item.last <= 1'b0;
          cur_r <= lk_rd;
          steps_r <= steps_r + 1'b1;
          if (cur_r == wtail_r[ev] || 32'(steps_r) >= MAX_TASKS - 1) wne_r[ev] <= 1'b0;
        end
        S_REP: begin
          out_valid <= 1'b1;
          out_item.kind <= 1'b0;
          out_item.out_task <= 4'(run_r);
          out_item.out_data <= (cmd_r.cmd == CMD_WAIT && ev_run == run_r && !sw_r)
                               ? cmd_r.data_word : word_rd;
          out_item.switched <= sw_r;
          out_item.last <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

### hdl/fts_checker.sv
// fts_checker: port-level checks for the task scheduler, bound to the top level.
// Depends on fts_pkg.
module fts_checker
  import fts_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input fts_out_t out_item
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");

  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |-> busy) else $error("woken item while idle");

  a_woken_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.kind) |-> (!out_item.last && !out_item.switched))
    else $error("bad woken item");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |-> !busy) else $error("busy after last");

endmodule

bind fifo_task_scheduler_with_event_waits fts_checker u_fts_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
